// ===== rtl/tlg_pkg.sv =====
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared types, constants and cell update rule for the toroidal life block
// ----------------------------------------------------------------------------
package tlg_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = X_W + Y_W;
    localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;

    localparam int DIM_W      = 7;
    localparam int CELL_W     = 8;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [DIM_W-1:0]  GRID_WIDTH_RST  = DIM_W'(64);
    localparam logic [DIM_W-1:0]  GRID_HEIGHT_RST = DIM_W'(64);
    localparam logic [CELL_W-1:0] FADE_LIMIT_RST  = CELL_W'(63);

    localparam logic [CNT_W-1:0] BORN_COUNT = CNT_W'(3);
    localparam logic [CNT_W-1:0] KEEP_COUNT = CNT_W'(2);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_FADE_LIMIT  = 2'd2
    } reg_idx_t;

    // read address source
    typedef enum logic [2:0] {
        RD_REQ  = 3'd0,
        RD_LAST = 3'd1,
        RD_ZERO = 3'd2,
        RD_NEXT = 3'd3,
        RD_CUR  = 3'd4
    } rd_sel_t;

    // where returning read data goes
    typedef enum logic [2:0] {
        DST_NONE = 3'd0,
        DST_RES  = 3'd1,
        DST_PREV = 3'd2,
        DST_CUR  = 3'd3,
        DST_NEXT = 3'd4,
        DST_UPD  = 3'd5
    } dst_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [5:0]        cell_x;
        logic [5:0]        cell_y;
        logic [CELL_W-1:0] cell_value;
    } in_t;

    typedef struct packed {
        logic [CELL_W-1:0] read_value;
        logic              still_fading;
    } out_t;

    typedef struct packed {
        logic    start;
        logic    wr_req;
        logic    rd_issue;
        rd_sel_t rd_sel;
        dst_t    dst;
        logic    x_clear;
        logic    x_inc;
        logic    y_clear;
        logic    y_inc;
        logic    shift;
        logic    next_from_save;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic x_last;
        logic y_wrap;
    } stat_t;

    function automatic logic [CELL_W-1:0] next_cell(
        input logic [CELL_W-1:0] cur_val,
        input logic [CNT_W-1:0]  count,
        input logic [CELL_W-1:0] limit
    );
        logic [CELL_W-1:0] res;
        res = cur_val;
        if (count == BORN_COUNT) begin
            res = '0;
        end else if (count == KEEP_COUNT) begin
            if (cur_val != '0 && cur_val < limit) begin
                res = cur_val + 1'b1;
            end
        end else begin
            if (cur_val == '0) begin
                res = CELL_W'(1);
            end else if (cur_val < limit) begin
                res = cur_val + 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/tlg_ram.sv =====
// ----------------------------------------------------------------------------
// tlg_ram
// Generic simple dual-port RAM, one write port, one registered read port
// ----------------------------------------------------------------------------
module tlg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tlg_dp.sv =====
// ----------------------------------------------------------------------------
// tlg_dp
// Datapath: config registers, cell RAM, live row buffers, update rule, output
// ----------------------------------------------------------------------------
module tlg_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tlg_pkg::cmd_t                  cmd,
    output tlg_pkg::stat_t                 stat,
    input  tlg_pkg::in_t                   s_data,
    input  logic                           cfg_wr_en,
    input  logic [tlg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlg_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output tlg_pkg::out_t                  m_data
);

    logic [tlg_pkg::DIM_W-1:0]     width_reg;
    logic [tlg_pkg::DIM_W-1:0]     height_reg;
    logic [tlg_pkg::CELL_W-1:0]    limit_reg;
    logic [tlg_pkg::DIM_W-1:0]     wc;
    logic [tlg_pkg::DIM_W-1:0]     hc;

    logic [tlg_pkg::X_W-1:0]       x_reg;
    logic [tlg_pkg::Y_W-1:0]       y_reg;

    logic [tlg_pkg::ADDR_W-1:0]    req_addr;
    logic                          req_inside;
    logic [tlg_pkg::ADDR_W-1:0]    rd_addr;
    logic [tlg_pkg::CELL_W-1:0]    rd_data;

    tlg_pkg::dst_t                 pend_dst_reg;
    logic [tlg_pkg::ADDR_W-1:0]    pend_addr_reg;
    logic                          pend_inside_reg;
    logic [tlg_pkg::X_W-1:0]       ux;
    logic [tlg_pkg::X_W-1:0]       uxm;
    logic [tlg_pkg::X_W-1:0]       uxp;

    logic [tlg_pkg::MAX_WIDTH-1:0] prev_reg;
    logic [tlg_pkg::MAX_WIDTH-1:0] cur_reg;
    logic [tlg_pkg::MAX_WIDTH-1:0] next_reg;
    logic [tlg_pkg::MAX_WIDTH-1:0] save_reg;
    logic                          live_in;
    logic                          row_fill;

    logic [tlg_pkg::CNT_W-1:0]     count;
    logic [tlg_pkg::CELL_W-1:0]    new_val;

    logic                          we;
    logic [tlg_pkg::ADDR_W-1:0]    waddr;
    logic [tlg_pkg::CELL_W-1:0]    wdata;

    logic                          fade_reg;
    logic                          step_reg;
    logic [tlg_pkg::CELL_W-1:0]    res_value_reg;
    tlg_pkg::out_t                 m_data_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= tlg_pkg::GRID_WIDTH_RST;
            height_reg <= tlg_pkg::GRID_HEIGHT_RST;
            limit_reg  <= tlg_pkg::FADE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tlg_pkg::REG_GRID_WIDTH: begin
                    width_reg <= cfg_wr_data[tlg_pkg::DIM_W-1:0];
                end
                tlg_pkg::REG_GRID_HEIGHT: begin
                    height_reg <= cfg_wr_data[tlg_pkg::DIM_W-1:0];
                end
                tlg_pkg::REG_FADE_LIMIT: begin
                    limit_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    // used area, clamped to storage
    always_comb begin
        if (width_reg == '0) begin
            wc = tlg_pkg::DIM_W'(1);
        end else if (width_reg > tlg_pkg::DIM_W'(tlg_pkg::MAX_WIDTH)) begin
            wc = tlg_pkg::DIM_W'(tlg_pkg::MAX_WIDTH);
        end else begin
            wc = width_reg;
        end
        if (height_reg == '0) begin
            hc = tlg_pkg::DIM_W'(1);
        end else if (height_reg > tlg_pkg::DIM_W'(tlg_pkg::MAX_HEIGHT)) begin
            hc = tlg_pkg::DIM_W'(tlg_pkg::MAX_HEIGHT);
        end else begin
            hc = height_reg;
        end
    end

    // walk counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            y_reg <= '0;
        end else begin
            if (cmd.x_clear) begin
                x_reg <= '0;
            end else if (cmd.x_inc) begin
                x_reg <= x_reg + 1'b1;
            end
            if (cmd.y_clear) begin
                y_reg <= '0;
            end else if (cmd.y_inc) begin
                y_reg <= y_reg + 1'b1;
            end
        end
    end

    assign stat.x_last = (tlg_pkg::DIM_W'(x_reg) == wc - 1'b1);
    assign stat.y_wrap = (tlg_pkg::DIM_W'(y_reg) == hc - 1'b1);

    // read address
    assign req_addr   = {tlg_pkg::Y_W'(s_data.cell_y), tlg_pkg::X_W'(s_data.cell_x)};
    assign req_inside = (int'(s_data.cell_x) < tlg_pkg::MAX_WIDTH)
                     && (int'(s_data.cell_y) < tlg_pkg::MAX_HEIGHT);

    always_comb begin
        case (cmd.rd_sel)
            tlg_pkg::RD_REQ:  rd_addr = req_addr;
            tlg_pkg::RD_LAST: rd_addr = {tlg_pkg::Y_W'(hc - 1'b1), x_reg};
            tlg_pkg::RD_ZERO: rd_addr = {{tlg_pkg::Y_W{1'b0}}, x_reg};
            tlg_pkg::RD_NEXT: rd_addr = {y_reg + 1'b1, x_reg};
            tlg_pkg::RD_CUR:  rd_addr = {y_reg, x_reg};
            default:          rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_dst_reg <= tlg_pkg::DST_NONE;
        end else begin
            pend_dst_reg <= cmd.rd_issue ? cmd.dst : tlg_pkg::DST_NONE;
        end
        pend_addr_reg   <= rd_addr;
        pend_inside_reg <= req_inside;
    end

    // neighbour count and new cell value
    always_comb begin
        ux  = pend_addr_reg[tlg_pkg::X_W-1:0];
        uxm = (ux == '0) ? tlg_pkg::X_W'(wc - 1'b1) : ux - 1'b1;
        uxp = (tlg_pkg::DIM_W'(ux) == wc - 1'b1) ? '0 : ux + 1'b1;
        count = tlg_pkg::CNT_W'(prev_reg[uxm]) + tlg_pkg::CNT_W'(prev_reg[ux])
              + tlg_pkg::CNT_W'(prev_reg[uxp]) + tlg_pkg::CNT_W'(cur_reg[uxm])
              + tlg_pkg::CNT_W'(cur_reg[uxp])  + tlg_pkg::CNT_W'(next_reg[uxm])
              + tlg_pkg::CNT_W'(next_reg[ux])  + tlg_pkg::CNT_W'(next_reg[uxp]);
        new_val = tlg_pkg::next_cell(rd_data, count, limit_reg);
    end

    // cell RAM write port
    always_comb begin
        if (pend_dst_reg == tlg_pkg::DST_UPD) begin
            we    = 1'b1;
            waddr = pend_addr_reg;
            wdata = new_val;
        end else begin
            we    = cmd.wr_req & req_inside;
            waddr = req_addr;
            wdata = s_data.cell_value;
        end
    end

    tlg_ram #(
        .WIDTH (tlg_pkg::CELL_W),
        .DEPTH (tlg_pkg::CELL_COUNT)
    ) u_grid (
        .clk   (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // live row buffers
    assign live_in  = (rd_data == '0);
    assign row_fill = pend_dst_reg inside {tlg_pkg::DST_PREV, tlg_pkg::DST_CUR,
                                           tlg_pkg::DST_NEXT};

    always_ff @(posedge aclk) begin
        case (pend_dst_reg)
            tlg_pkg::DST_PREV: begin
                prev_reg[ux] <= live_in;
            end
            tlg_pkg::DST_CUR: begin
                cur_reg[ux]  <= live_in;
                save_reg[ux] <= live_in;
            end
            tlg_pkg::DST_NEXT: begin
                next_reg[ux] <= live_in;
            end
            default: begin
            end
        endcase
        if (cmd.shift) begin
            prev_reg <= cur_reg;
            cur_reg  <= next_reg;
        end
        if (cmd.next_from_save) begin
            next_reg <= save_reg;
        end
    end

    // result
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            fade_reg      <= 1'b0;
            step_reg      <= (s_data.opcode == tlg_pkg::OP_STEP);
            res_value_reg <= '0;
        end else begin
            if (row_fill && rd_data > tlg_pkg::CELL_W'(1) && rd_data < limit_reg) begin
                fade_reg <= 1'b1;
            end
            if (pend_dst_reg == tlg_pkg::DST_RES) begin
                res_value_reg <= pend_inside_reg ? rd_data : '0;
            end
        end
        if (cmd.out_load) begin
            m_data_reg.read_value   <= res_value_reg;
            m_data_reg.still_fading <= step_reg & fade_reg;
        end
    end

    assign m_data = m_data_reg;

endmodule

// ===== rtl/tlg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlg_ctrl
// Controller: handshakes and the sequence of a generation sweep
// ----------------------------------------------------------------------------
module tlg_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic [1:0]     s_opcode,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output tlg_pkg::cmd_t  cmd,
    input  tlg_pkg::stat_t stat
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_RD_WAIT   = 9'b000000010,
        S_PRE_LAST  = 9'b000000100,
        S_PRE_FIRST = 9'b000001000,
        S_PRE_END   = 9'b000010000,
        S_LOAD      = 9'b000100000,
        S_UPDATE    = 9'b001000000,
        S_SHIFT     = 9'b010000000,
        S_RESULT    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start = 1'b1;
                    case (s_opcode)
                        tlg_pkg::OP_WRITE: begin
                            cmd.wr_req = 1'b1;
                            state_next = S_RESULT;
                        end
                        tlg_pkg::OP_READ: begin
                            cmd.rd_issue = 1'b1;
                            cmd.rd_sel   = tlg_pkg::RD_REQ;
                            cmd.dst      = tlg_pkg::DST_RES;
                            state_next   = S_RD_WAIT;
                        end
                        tlg_pkg::OP_STEP: begin
                            cmd.x_clear = 1'b1;
                            cmd.y_clear = 1'b1;
                            state_next  = S_PRE_LAST;
                        end
                        default: begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                state_next = S_RESULT;
            end
            S_PRE_LAST: begin
                cmd.rd_issue = 1'b1;
                cmd.rd_sel   = tlg_pkg::RD_LAST;
                cmd.dst      = tlg_pkg::DST_PREV;
                cmd.x_inc    = 1'b1;
                if (stat.x_last) begin
                    cmd.x_clear = 1'b1;
                    state_next  = S_PRE_FIRST;
                end
            end
            S_PRE_FIRST: begin
                cmd.rd_issue = 1'b1;
                cmd.rd_sel   = tlg_pkg::RD_ZERO;
                cmd.dst      = tlg_pkg::DST_CUR;
                cmd.x_inc    = 1'b1;
                if (stat.x_last) begin
                    cmd.x_clear = 1'b1;
                    state_next  = S_PRE_END;
                end
            end
            S_PRE_END: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (stat.y_wrap) begin
                    cmd.next_from_save = 1'b1;
                    state_next         = S_UPDATE;
                end else begin
                    cmd.rd_issue = 1'b1;
                    cmd.rd_sel   = tlg_pkg::RD_NEXT;
                    cmd.dst      = tlg_pkg::DST_NEXT;
                    cmd.x_inc    = 1'b1;
                    if (stat.x_last) begin
                        cmd.x_clear = 1'b1;
                        state_next  = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                cmd.rd_issue = 1'b1;
                cmd.rd_sel   = tlg_pkg::RD_CUR;
                cmd.dst      = tlg_pkg::DST_UPD;
                cmd.x_inc    = 1'b1;
                if (stat.x_last) begin
                    cmd.x_clear = 1'b1;
                    state_next  = stat.y_wrap ? S_RESULT : S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.shift  = 1'b1;
                cmd.y_inc  = 1'b1;
                state_next = S_LOAD;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/toroidal_life_generation_with_fade.sv =====
// ----------------------------------------------------------------------------
// toroidal_life_generation_with_fade
// Life grid on a torus with fade ages on dead cells, byte cells in one RAM
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one word per command (write cell, read cell, run generation)
//   m_ channel: exactly one result word per command, in command order
//   cfg_ port: grid width, grid height and fade limit, written while idle
// generation: with the single read port of the cell RAM, the last row and
//   the first row are loaded, then per row the next row is loaded and the
//   row is read, updated and written back one cell a cycle
// throughput: one command at a time; s_ready is high only between commands
// reset: registers go to 64 x 64 with fade limit 63, no result pending;
//   the cell RAM is not cleared, cells must be written before use
// stall: a result waits in the output register while m_ready is low; one
//   more command is still taken, its result then waits until the first leaves
// ----------------------------------------------------------------------------
module toroidal_life_generation_with_fade (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tlg_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tlg_pkg::out_t                  m_data,
    input  logic                           cfg_wr_en,
    input  logic [tlg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlg_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    tlg_pkg::cmd_t  cmd;
    tlg_pkg::stat_t stat;

    tlg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_data.opcode),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    tlg_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .m_data      (m_data)
    );

endmodule

// ===== rtl/tlg_checker.sv =====
// ----------------------------------------------------------------------------
// tlg_checker
// Port-level checks of the toroidal life block, bound to the top level
// ----------------------------------------------------------------------------
module tlg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input tlg_pkg::in_t                   s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input tlg_pkg::out_t                  m_data,
    input logic                           cfg_wr_en,
    input logic [tlg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [tlg_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    logic       s_acc;
    logic       m_acc;
    logic [1:0] cnt_reg;
    logic [1:0] op_reg;

    assign s_acc = s_valid & s_ready;
    assign m_acc = m_valid & m_ready;

    // words taken but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            op_reg  <= tlg_pkg::OP_NOP;
        end else begin
            cnt_reg <= cnt_reg + {1'b0, s_acc} - {1'b0, m_acc};
            if (s_acc) begin
                op_reg <= s_data.opcode;
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> cnt_reg == {1'b0, m_valid})
        else $error("ready while a command is still in work");

    a_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("more than two words in flight");

    a_fade_step_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && cnt_reg == 2'd1 && op_reg != tlg_pkg::OP_STEP |-> !m_data.still_fading)
        else $error("fading flag on a non-generation result");

    a_value_read_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && cnt_reg == 2'd1 && op_reg != tlg_pkg::OP_READ |-> m_data.read_value == '0)
        else $error("cell value on a non-read result");

    logic unused_cfg;
    assign unused_cfg = cfg_wr_en ^ (^cfg_index) ^ (^cfg_wr_data);

endmodule

bind toroidal_life_generation_with_fade tlg_checker u_tlg_checker (.*);
